// ===== design/h2r_pkg.sv =====
// Package for the HSL to RGB converter: fixed-point widths, constants,
// and the item types shared by the front end, the queue and the back end.
// No dependencies.
package h2r_pkg;

  // Fixed-point format: ONE = 2^FRAC_BITS means 1.0
  localparam int FRAC_BITS = 16;
  localparam int FW        = FRAC_BITS + 1;
  localparam logic [FW-1:0] ONE = FW'(1) << FRAC_BITS;

  // Field widths of the interface
  localparam int HUE_W = 16;
  localparam int SL_W  = 17;
  localparam int CH_W  = 8;
  localparam int EPS_W = 17;
  localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);

  // Configuration port
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;
  localparam logic REG_GRAY_EPS = 1'b0;

  // Queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = 2;
  typedef logic [QAW:0] qcnt_t;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [SL_W-1:0]  saturation;
    logic [SL_W-1:0]  lightness;
  } pixel_t;

  typedef struct packed {
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] red;
  } color_t;

  // Item handed from front to back; a grey item carries m1 = m2 = lightness
  typedef struct packed {
    logic [FRAC_BITS-1:0] hue;
    logic [FW-1:0]        m1;
    logic [FW-1:0]        m2;
  } q_item_t;

  // Queue status seen by the front end and the back end
  typedef struct packed {
    qcnt_t count;
    logic  empty;
  } q_status_t;

endpackage

// ===== design/hsl_to_rgb_converter_unit.sv =====
// Top level of the HSL to RGB converter: configuration register, front end,
// queue and back end. Depends on h2r_pkg, h2r_front, h2r_queue, h2r_back.
//
// Takes one pixel per clock: a pixel is taken when start is high and busy is
// low, and its blue/green/red bytes appear on color with done high for one
// cycle, after the input stage, the queue and the back end. The back end is a fixed
// four-stage pipeline that drains the queue every cycle, so busy stays low
// under continuous input; results cannot be held off and must be captured in
// the cycle done is high. gray_epsilon sits at byte address 0; saturation
// below it gives a grey pixel from lightness. Write it only while idle.
module hsl_to_rgb_converter_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  h2r_pkg::pixel_t               pixel,
  output logic                          done,
  output h2r_pkg::color_t               color,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [h2r_pkg::ADDR_W-1:0]    paddr,
  input  logic [h2r_pkg::DATA_W-1:0]    pwdata,
  output logic [h2r_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import h2r_pkg::*;

  logic [EPS_W-1:0] gray_epsilon;
  logic             reg_hit;
  logic             push;
  logic             pop;
  q_item_t          push_item;
  q_item_t          pop_item;
  q_status_t        q_status;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = (paddr[ADDR_W-1:2] == REG_GRAY_EPS);

  always_ff @(posedge clk) begin
    if (rst) begin
      gray_epsilon <= EPS_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      gray_epsilon <= pwdata[EPS_W-1:0];
    end
  end

  assign prdata = reg_hit ? DATA_W'(gray_epsilon) : '0;

  h2r_front u_front (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .pixel        (pixel),
    .gray_epsilon (gray_epsilon),
    .q_status     (q_status),
    .busy         (busy),
    .push         (push),
    .push_item    (push_item)
  );

  h2r_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  h2r_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .item     (pop_item),
    .pop      (pop),
    .done     (done),
    .color    (color)
  );

endmodule

// ===== design/h2r_front.sv =====
// Front end of the HSL to RGB converter: accepts pixels, saturates them,
// classifies grey, and works out m1/m2. Depends on h2r_pkg.
module h2r_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  h2r_pkg::pixel_t               pixel,
  input  logic [h2r_pkg::EPS_W-1:0]     gray_epsilon,
  input  h2r_pkg::q_status_t            q_status,
  output logic                          busy,
  output logic                          push,
  output h2r_pkg::q_item_t              push_item
);
  import h2r_pkg::*;

  logic                 accept;
  logic [FW-1:0]        s_c;
  logic [FW-1:0]        l_c;
  logic                 a_valid;
  logic [FRAC_BITS-1:0] a_h;
  logic [FW-1:0]        a_s;
  logic [FW-1:0]        a_l;
  logic                 a_grey;
  logic [2*FW-1:0]      a_prod;
  logic [FW-1:0]        p;
  logic signed [FW+1:0] hi_s;
  logic signed [FW+1:0] lo_s;
  logic [FW-1:0]        hi_c;
  logic [FW-1:0]        lo_c;

  // Credit check: items in the input stage plus queued items
  assign busy   = (qcnt_t'(a_valid) + q_status.count) >= qcnt_t'(QDEPTH);
  assign accept = start & ~busy;

  // Saturate to 1.0 before any use
  assign s_c = (FW'(pixel.saturation) > ONE) ? ONE : FW'(pixel.saturation);
  assign l_c = (FW'(pixel.lightness) > ONE) ? ONE : FW'(pixel.lightness);

  // Input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_h    <= FRAC_BITS'(pixel.hue);
      a_s    <= s_c;
      a_l    <= l_c;
      a_grey <= s_c < FW'(gray_epsilon);
      a_prod <= s_c * l_c;
    end
  end

  // m2 = l + l*s when l <= 1/2, else l + s - l*s; m1 = 2l - m2
  assign p = a_prod[FRAC_BITS +: FW];

  always_comb begin
    if (a_l <= (ONE >> 1)) begin
      hi_s = $signed({2'b00, a_l}) + $signed({2'b00, p});
    end else begin
      hi_s = $signed({2'b00, a_l}) + $signed({2'b00, a_s}) - $signed({2'b00, p});
    end
    lo_s = ($signed({2'b00, a_l}) <<< 1) - hi_s;
  end

  // Clamp m2 to [0, 1] and m1 to [0, m2]
  always_comb begin
    if (hi_s < 0) begin
      hi_c = '0;
    end else if (hi_s > $signed({2'b00, ONE})) begin
      hi_c = ONE;
    end else begin
      hi_c = hi_s[FW-1:0];
    end
    if (lo_s < 0) begin
      lo_c = '0;
    end else if (lo_s > $signed({2'b00, hi_c})) begin
      lo_c = hi_c;
    end else begin
      lo_c = lo_s[FW-1:0];
    end
  end

  // Grey forces a flat ramp at lightness
  assign push           = a_valid;
  assign push_item.hue  = a_h;
  assign push_item.m2   = a_grey ? a_l : hi_c;
  assign push_item.m1   = a_grey ? a_l : lo_c;

endmodule

// ===== design/h2r_queue.sv =====
// Short queue between the front end and the back end of the converter.
// Depends on h2r_pkg.
module h2r_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  h2r_pkg::q_item_t   push_item,
  input  logic               pop,
  output h2r_pkg::q_item_t   pop_item,
  output h2r_pkg::q_status_t status
);
  import h2r_pkg::*;

  q_item_t        slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  qcnt_t          count;
  logic           do_pop;

  assign do_pop = pop & (count != '0);

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      count <= count + qcnt_t'(push) - qcnt_t'(do_pop);
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  assign pop_item     = slots[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);

endmodule

// ===== design/h2r_back.sv =====
// Back end of the converter: evaluates the hue ramp for the three channels
// in lanes over four register stages and scales to 8 bits. Depends on h2r_pkg.
module h2r_back (
  input  logic               clk,
  input  logic               rst,
  input  h2r_pkg::q_status_t q_status,
  input  h2r_pkg::q_item_t   item,
  output logic               pop,
  output logic               done,
  output h2r_pkg::color_t    color
);
  import h2r_pkg::*;

  // Ramp segments
  localparam logic [1:0] SEG_RISE = 2'd0;
  localparam logic [1:0] SEG_PLAT = 2'd1;
  localparam logic [1:0] SEG_FALL = 2'd2;
  localparam logic [1:0] SEG_LOW  = 2'd3;

  // Tripled-phase arithmetic width and constants
  localparam int PW = FRAC_BITS + 3;
  localparam logic [PW-1:0] P_ONE   = PW'(1) << FRAC_BITS;
  localparam logic [PW-1:0] P_TWO   = P_ONE << 1;
  localparam logic [PW-1:0] P_THREE = P_ONE + P_TWO;
  localparam logic [PW-1:0] P_FOUR  = P_ONE << 2;
  localparam int NL = 3;

  logic [PW-1:0]   u3;
  logic [PW-1:0]   sum_r;
  logic [PW-1:0]   sum_b;
  logic [PW-1:0]   ph    [NL];
  logic [PW-1:0]   tw    [NL];
  logic [1:0]      seg   [NL];
  logic [FW-1:0]   x     [NL];

  logic            c1_valid;
  logic [1:0]      c1_seg [NL];
  logic [FW-1:0]   c1_x   [NL];
  logic [FW-1:0]   c1_m1;
  logic [FW-1:0]   c1_m2;
  logic [FW-1:0]   c1_d;

  logic            c2_valid;
  logic [1:0]      c2_seg  [NL];
  logic [2*FW-1:0] c2_prod [NL];
  logic [FW-1:0]   c2_m1;
  logic [FW-1:0]   c2_m2;

  logic [FW:0]     v_sum [NL];
  logic [FW-1:0]   v     [NL];
  logic            c3_valid;
  logic [FW-1:0]   c3_v  [NL];

  logic [FW+7:0]   scaled [NL];

  // The back end never stalls: take an item whenever one is queued
  assign pop = ~q_status.empty;

  // Phases: lane 0 blue at hue-1/3, lane 1 green at hue, lane 2 red at hue+1/3
  assign u3    = PW'(item.hue) + (PW'(item.hue) << 1);
  assign sum_r = u3 + P_ONE;
  assign sum_b = u3 + P_TWO;

  always_comb begin
    ph[0] = (sum_b >= P_THREE) ? sum_b - P_THREE : sum_b;
    ph[1] = u3;
    ph[2] = (sum_r >= P_THREE) ? sum_r - P_THREE : sum_r;
  end

  // Segment select and multiplier operand per lane
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      tw[i] = ph[i] << 1;
      if (tw[i] < P_ONE) begin
        seg[i] = SEG_RISE;
        x[i]   = tw[i][FW-1:0];
      end else if (tw[i] < P_THREE) begin
        seg[i] = SEG_PLAT;
        x[i]   = '0;
      end else if (ph[i] < P_TWO) begin
        seg[i] = SEG_FALL;
        x[i]   = FW'(P_FOUR - tw[i]);
      end else begin
        seg[i] = SEG_LOW;
        x[i]   = '0;
      end
    end
  end

  // Valid pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      c1_valid <= 1'b0;
      c2_valid <= 1'b0;
      c3_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      c1_valid <= pop;
      c2_valid <= c1_valid;
      c3_valid <= c2_valid;
      done     <= c3_valid;
    end
  end

  // Stage 1: phase and segment
  always_ff @(posedge clk) begin
    c1_m1 <= item.m1;
    c1_m2 <= item.m2;
    c1_d  <= item.m2 - item.m1;
    for (int i = 0; i < NL; i++) begin
      c1_seg[i] <= seg[i];
      c1_x[i]   <= x[i];
    end
  end

  // Stage 2: ramp products
  always_ff @(posedge clk) begin
    c2_m1 <= c1_m1;
    c2_m2 <= c1_m2;
    for (int i = 0; i < NL; i++) begin
      c2_seg[i]  <= c1_seg[i];
      c2_prod[i] <= c1_d * c1_x[i];
    end
  end

  // Stage 3: ramp value, clamped to 1.0
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      unique case (c2_seg[i])
        SEG_RISE, SEG_FALL: v_sum[i] = {1'b0, c2_m1} + {1'b0, c2_prod[i][FRAC_BITS +: FW]};
        SEG_PLAT:           v_sum[i] = {1'b0, c2_m2};
        SEG_LOW:            v_sum[i] = {1'b0, c2_m1};
        default:            v_sum[i] = {1'b0, c2_m1};
      endcase
      v[i] = (v_sum[i] > {1'b0, ONE}) ? ONE : v_sum[i][FW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NL; i++) begin
      c3_v[i] <= v[i];
    end
  end

  // Stage 4: scale by 255 and truncate
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      scaled[i] = ((FW+8)'(c3_v[i]) << 8) - (FW+8)'(c3_v[i]);
    end
  end

  always_ff @(posedge clk) begin
    color.blue  <= scaled[0][FRAC_BITS +: CH_W];
    color.green <= scaled[1][FRAC_BITS +: CH_W];
    color.red   <= scaled[2][FRAC_BITS +: CH_W];
  end

endmodule
